// ----- hw/rtl/dlssr_pkg.sv -----
package dlssr_pkg;

  localparam int unsigned FS_W      = 4;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SAMPLE_W  = 20;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned MODE_W    = 2;

  localparam logic [SAMPLE_W-1:0] TIMEOUT_RESET = 20'd1000;

  // receiver frame states
  localparam logic [FS_W-1:0] FS_START     = 4'd0;
  localparam logic [FS_W-1:0] FS_LAST_DATA = 4'd8;
  localparam logic [FS_W-1:0] FS_STOP      = 4'd9;
  localparam logic [FS_W-1:0] FS_OK        = 4'd10;
  localparam logic [FS_W-1:0] FS_ERR       = 4'd11;

  // message mode
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HUNT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FRAME   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  typedef struct packed {
    logic                new_message;
    logic [COUNT_W-1:0]  message_bytes;
    logic                line0_bit;
    logic                line1_bit;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_byte;
    logic                line_used;
    logic [COUNT_W-1:0]  byte_index;
    logic                message_done;
  } result_t;

endpackage

// ----- hw/rtl/dlssr_frame_rx.sv -----
// One start/stop receiver: advances frame state and shift register by one sample.
module dlssr_frame_rx
  import dlssr_pkg::*;
(
  input  logic [FS_W-1:0]   fs_in,
  input  logic [DATA_W-1:0] sh_in,
  input  logic              sample_bit,
  output logic [FS_W-1:0]   fs_out,
  output logic [DATA_W-1:0] sh_out
);

  logic [FS_W-1:0] bit_pos;

  // data bits arrive MSB first: state 1 -> bit 7 ... state 8 -> bit 0
  assign bit_pos = FS_LAST_DATA - fs_in;

  always_comb begin
    fs_out = fs_in;
    sh_out = sh_in;
    if (fs_in == FS_START) begin
      if (!sample_bit) fs_out = FS_START + 4'd1;
    end else if (fs_in <= FS_LAST_DATA) begin
      if (sample_bit) sh_out = sh_in | (DATA_W'(1) << bit_pos[2:0]);
      fs_out = fs_in + 4'd1;
    end else if (fs_in == FS_STOP) begin
      fs_out = sample_bit ? FS_OK : FS_ERR;
    end
  end

endmodule

// ----- hw/rtl/dlssr_core.sv -----
// Message state and per-sample update; one item per step.
module dlssr_core
  import dlssr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [SAMPLE_W-1:0] cfg_wr_data,
  input  logic                step,
  input  item_t               item,
  output logic                res_valid,
  output result_t             res
);

  logic [SAMPLE_W-1:0] timeout_limit_r;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [FS_W-1:0]     fs_a_r, fs_a_nxt, fs_b_r, fs_b_nxt;
  logic [DATA_W-1:0]   sh_a_r, sh_a_nxt, sh_b_r, sh_b_nxt;
  logic                locked_r, locked_nxt;
  logic [SAMPLE_W-1:0] sc_r, sc_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt, done_r, done_nxt;

  // state after a new-message load, before the sample
  logic [MODE_W-1:0]   mode_eff;
  logic [FS_W-1:0]     fs_a_eff, fs_b_eff, fs_a_p, fs_b_p;
  logic [DATA_W-1:0]   sh_a_eff, sh_b_eff, sh_a_p, sh_b_p;
  logic                locked_eff;
  logic [SAMPLE_W-1:0] sc_eff;
  logic [COUNT_W-1:0]  left_eff, done_eff;
  logic                bit_a;

  assign mode_eff   = item.new_message ?
                      ((item.message_bytes == '0) ? MODE_IDLE : MODE_HUNT) : mode_r;
  assign fs_a_eff   = item.new_message ? FS_START : fs_a_r;
  assign fs_b_eff   = item.new_message ? FS_START : fs_b_r;
  assign sh_a_eff   = item.new_message ? '0 : sh_a_r;
  assign sh_b_eff   = item.new_message ? '0 : sh_b_r;
  assign sc_eff     = item.new_message ? '0 : sc_r;
  assign locked_eff = item.new_message ? 1'b0 : locked_r;
  assign left_eff   = item.new_message ? item.message_bytes : left_r;
  assign done_eff   = item.new_message ? '0 : done_r;

  // hunting: a follows line 0; locked: a follows the locked line
  assign bit_a = (mode_eff == MODE_LOCKED && locked_eff) ? item.line1_bit : item.line0_bit;

  dlssr_frame_rx u_rx_a (
    .fs_in      (fs_a_eff),
    .sh_in      (sh_a_eff),
    .sample_bit (bit_a),
    .fs_out     (fs_a_p),
    .sh_out     (sh_a_p)
  );

  dlssr_frame_rx u_rx_b (
    .fs_in      (fs_b_eff),
    .sh_in      (sh_b_eff),
    .sample_bit (item.line1_bit),
    .fs_out     (fs_b_p),
    .sh_out     (sh_b_p)
  );

  always_comb begin
    logic                emit_v;
    logic [STATUS_W-1:0] st_v;
    logic [DATA_W-1:0]   data_v;
    logic                ends_v;

    emit_v     = 1'b0;
    st_v       = ST_OK;
    data_v     = '0;
    ends_v     = 1'b0;
    mode_nxt   = mode_r;
    fs_a_nxt   = fs_a_r;
    fs_b_nxt   = fs_b_r;
    sh_a_nxt   = sh_a_r;
    sh_b_nxt   = sh_b_r;
    locked_nxt = locked_r;
    sc_nxt     = sc_r;
    left_nxt   = left_r;
    done_nxt   = done_r;
    res_valid  = 1'b0;
    res        = '0;

    if (step) begin
      mode_nxt   = mode_eff;
      fs_a_nxt   = fs_a_eff;
      fs_b_nxt   = fs_b_eff;
      sh_a_nxt   = sh_a_eff;
      sh_b_nxt   = sh_b_eff;
      locked_nxt = locked_eff;
      sc_nxt     = sc_eff;
      left_nxt   = left_eff;
      done_nxt   = done_eff;

      case (mode_eff)
        MODE_HUNT: begin
          fs_a_nxt = fs_a_p;
          sh_a_nxt = sh_a_p;
          fs_b_nxt = fs_b_p;
          sh_b_nxt = sh_b_p;
          if (fs_a_p == FS_OK) begin
            locked_nxt = 1'b0;
            emit_v     = 1'b1;
            data_v     = sh_a_p;
            ends_v     = (left_eff == COUNT_W'(1));
          end else if (fs_b_p == FS_OK) begin
            locked_nxt = 1'b1;
            emit_v     = 1'b1;
            data_v     = sh_b_p;
            ends_v     = (left_eff == COUNT_W'(1));
          end else if (fs_a_p == FS_ERR && fs_b_p == FS_ERR) begin
            emit_v = 1'b1;
            st_v   = ST_FRAME;
            ends_v = 1'b1;
          end
        end
        MODE_LOCKED: begin
          fs_a_nxt = fs_a_p;
          sh_a_nxt = sh_a_p;
          if (fs_a_p == FS_OK) begin
            emit_v = 1'b1;
            data_v = sh_a_p;
            ends_v = (left_eff == COUNT_W'(1));
          end else if (fs_a_p == FS_ERR) begin
            emit_v = 1'b1;
            st_v   = ST_FRAME;
            data_v = sh_a_p;
            ends_v = 1'b1;
          end
        end
        default: ;
      endcase

      if (mode_eff != MODE_IDLE && !emit_v) begin
        if (sc_eff >= timeout_limit_r) begin
          emit_v = 1'b1;
          st_v   = ST_TIMEOUT;
          ends_v = 1'b1;
        end else begin
          sc_nxt = sc_eff + SAMPLE_W'(1);
        end
      end

      if (emit_v) begin
        res_valid        = 1'b1;
        res.status       = st_v;
        res.data_byte    = data_v;
        res.line_used    = locked_nxt;
        res.byte_index   = done_eff;
        res.message_done = ends_v;
        mode_nxt = ends_v ? MODE_IDLE : MODE_LOCKED;
        if (st_v == ST_OK) begin
          done_nxt = done_eff + COUNT_W'(1);
          left_nxt = left_eff - COUNT_W'(1);
        end
        fs_a_nxt = FS_START;
        fs_b_nxt = FS_START;
        sh_a_nxt = '0;
        sh_b_nxt = '0;
        sc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_RESET;
      mode_r          <= MODE_IDLE;
      fs_a_r          <= FS_START;
      fs_b_r          <= FS_START;
      sh_a_r          <= '0;
      sh_b_r          <= '0;
      locked_r        <= 1'b0;
      sc_r            <= '0;
      left_r          <= '0;
      done_r          <= '0;
    end else begin
      if (cfg_wr_en) timeout_limit_r <= cfg_wr_data;
      mode_r   <= mode_nxt;
      fs_a_r   <= fs_a_nxt;
      fs_b_r   <= fs_b_nxt;
      sh_a_r   <= sh_a_nxt;
      sh_b_r   <= sh_b_nxt;
      locked_r <= locked_nxt;
      sc_r     <= sc_nxt;
      left_r   <= left_nxt;
      done_r   <= done_nxt;
    end
  end

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_OK |-> res.message_done)
    else $error("error or timeout result does not end the message");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.message_done |=> mode_r == MODE_IDLE)
    else $error("message ended but mode not idle");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> sc_r == '0)
    else $error("sample count running while idle");

  a_locked_b: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_LOCKED |-> fs_b_r == FS_START)
    else $error("second receiver active while locked");

endmodule

// ----- hw/rtl/dual_line_start_stop_receiver.sv -----
// Two-line 8N1 receiver (MSB first). Each input item is one sample of both lines;
// an item that completes a byte, hits a frame error or times out gives one result
// item. Throughput is one item per clock while neither side stalls: the whole
// receiver update is combinational between the input register and the result
// register, which drives the output. Both sides may stall freely; while a result
// waits on out_tready the input register still takes one item if it is empty, and
// a full input register then holds in_tready low. The user must write
// timeout_limit via cfg_wr_en/cfg_wr_data only while no message runs; unenforced.
module dual_line_start_stop_receiver
  import dlssr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,   // timeout_limit

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [15:0] message_bytes, [16] line0_bit,
                                     // [17] line1_bit, [23:18] zero
  input  logic        in_tuser,      // new_message

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] data_byte, [8] line_used,
                                     // [24:9] byte_index, [31:25] zero
  output logic [1:0]  out_tuser,     // status
  output logic        out_tlast      // message_done
);

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  logic    adv;
  logic    res_valid;
  result_t res;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        in_valid_r  <= in_tvalid;
        out_valid_r <= res_valid;
      end else if (!in_valid_r) begin
        in_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.new_message   <= in_tuser;
      item_r.message_bytes <= in_tdata[15:0];
      item_r.line0_bit     <= in_tdata[16];
      item_r.line1_bit     <= in_tdata[17];
    end
    if (adv && res_valid) res_r <= res;
  end

  dlssr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (in_valid_r && adv),
    .item        (item_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.byte_index, res_r.line_used, res_r.data_byte};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.message_done;

endmodule
